[design/cse_pkg.sv]
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types and constants for the compact struct field encoder.
// ----------------------------------------------------------------------------
package cse_pkg;

  // Nesting stack size and derived widths
  localparam int unsigned STACK_DEPTH = 8;
  localparam int unsigned LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Job queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Token field widths
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned FID_W   = 16;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned ETYPE_W = 4;
  localparam int unsigned IN_DATA_W = 88;

  // Token kinds
  typedef enum logic [KIND_W-1:0] {
    K_I32         = 4'd0,
    K_I64         = 4'd1,
    K_BOOL        = 4'd2,
    K_BINARY      = 4'd3,
    K_LIST        = 4'd4,
    K_STRUCT      = 4'd5,
    K_BARE_STRUCT = 4'd6,
    K_STOP        = 4'd7,
    K_UVAR        = 4'd8,
    K_ZZ32        = 4'd9,
    K_ZZ64        = 4'd10,
    K_RAW         = 4'd11
  } req_kind_e;

  // Compact wire type codes
  localparam logic [3:0] CT_TRUE   = 4'd1;
  localparam logic [3:0] CT_FALSE  = 4'd2;
  localparam logic [3:0] CT_I32    = 4'd5;
  localparam logic [3:0] CT_I64    = 4'd6;
  localparam logic [3:0] CT_BINARY = 4'd8;
  localparam logic [3:0] CT_LIST   = 4'd9;
  localparam logic [3:0] CT_STRUCT = 4'd12;

  localparam logic [7:0]       STOP_BYTE      = 8'h00;
  localparam logic [3:0]       LIST_LONG_NIB  = 4'hF;
  localparam logic [VAL_W-1:0] SHORT_LIST_MAX = 64'd15;

  // One encoding job: up to four byte segments, emitted in this order
  typedef struct packed {
    logic             has_hdr;   // type byte
    logic [7:0]       hdr_byte;
    logic             has_idv;   // zigzag varint of the field id
    logic [FID_W-1:0] idv;
    logic             has_mid;   // single byte (list size, stop, raw)
    logic [7:0]       mid_byte;
    logic             has_val;   // varint of the value
    logic [VAL_W-1:0] val_word;
    logic             err;       // nesting overflow
  } job_t;

endpackage

[design/compact_struct_field_encoder.sv]
// ----------------------------------------------------------------------------
// compact_struct_field_encoder
// Compact binary struct encoder: serializer tokens in, encoded bytes out.
// ----------------------------------------------------------------------------
// Each token on the slave stream is turned into zero or more bytes on the
// master stream, one byte per transaction, with tlast on the final byte of
// the token's run and tuser set on every byte of a struct field token whose
// push found the nesting stack full. The front end takes one token per cycle
// while its job queue has room, updates the field id delta and nesting
// state, and queues an encoding job; bare struct starts and unused kinds
// produce no job. The back end emits one byte per cycle while its output
// register can take it, and loads the next job from the queue only after
// every byte of the current job has gone out. A registered output stage
// holds each byte stable for the downstream side; the back end advances
// whenever that register is empty or taken in the same cycle, and stalls
// with it otherwise, while the job queue lets the front end keep taking
// tokens.
module compact_struct_field_encoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [cse_pkg::IN_DATA_W-1:0]   s_tdata,   // [15:0] field_id, [79:16] value,
                                                     // [83:80] etype, [87:84] zero
  input  logic [3:0]                      s_tuser,   // [3:0] req_type
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // [7:0] out_byte
  output logic                            m_tlast,   // last_byte
  output logic                            m_tuser    // [0] nest_error
);
  import cse_pkg::*;

  logic tok_fire;
  logic job_push;
  job_t job_in;
  job_t job_out;
  logic q_empty;
  logic q_full;
  logic job_pop;

  // Hold off new tokens while the job queue is full
  assign s_tready = !q_full;
  assign tok_fire = s_tvalid && s_tready;

  cse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_fire_i  (tok_fire),
    .req_type_i  (s_tuser),
    .field_id_i  (s_tdata[15:0]),
    .value_i     (s_tdata[79:16]),
    .etype_i     (s_tdata[83:80]),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  cse_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_in),
    .pop_i       (job_pop),
    .pop_data_o  (job_out),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  cse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_empty_i (q_empty),
    .job_pop_o   (job_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

endmodule

[design/cse_front.sv]
// ----------------------------------------------------------------------------
// cse_front
// Token front end: tracks field ids and nesting, builds encoding jobs.
// ----------------------------------------------------------------------------
module cse_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tok_fire_i,
  input  logic [3:0]                    req_type_i,
  input  logic [15:0]                   field_id_i,
  input  logic [63:0]                   value_i,
  input  logic [cse_pkg::ETYPE_W-1:0]   etype_i,
  output logic                          job_push_o,
  output cse_pkg::job_t                 job_o
);
  import cse_pkg::*;

  logic [FID_W-1:0] cur_id_q, cur_id_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [FID_W-1:0] stack_q [STACK_DEPTH];

  logic [FID_W-1:0] delta;
  logic             short_hdr;
  logic             stack_full;
  logic [LVL_W-1:0] lvl_m1;
  logic [FID_W-1:0] id_zz;
  logic [VAL_W-1:0] val_zz32;
  logic [VAL_W-1:0] val_zz64;
  logic             is_hdr;
  logic [3:0]       hdr_type;
  logic             do_push;
  logic [FID_W-1:0] push_id;
  logic             enq;
  req_kind_e        kind;

  assign kind       = req_kind_e'(req_type_i);
  assign delta      = field_id_i - cur_id_q;
  assign short_hdr  = (delta[FID_W-1:4] == '0) && (delta[3:0] != 4'd0);
  assign stack_full = (lvl_q == LVL_W'(STACK_DEPTH));
  assign lvl_m1     = lvl_q - LVL_W'(1);
  assign id_zz      = {field_id_i[FID_W-2:0], 1'b0} ^ {FID_W{field_id_i[FID_W-1]}};
  assign val_zz32   = {32'd0, {value_i[30:0], 1'b0} ^ {32{value_i[31]}}};
  assign val_zz64   = {value_i[VAL_W-2:0], 1'b0} ^ {VAL_W{value_i[VAL_W-1]}};

  always_comb begin
    job_o    = '0;
    is_hdr   = 1'b0;
    hdr_type = 4'd0;
    do_push  = 1'b0;
    push_id  = cur_id_q;
    enq      = 1'b1;
    cur_id_d = cur_id_q;
    lvl_d    = lvl_q;
    case (kind)
      K_I32: begin
        is_hdr         = 1'b1;
        hdr_type       = CT_I32;
        job_o.has_val  = 1'b1;
        job_o.val_word = val_zz32;
      end
      K_I64: begin
        is_hdr         = 1'b1;
        hdr_type       = CT_I64;
        job_o.has_val  = 1'b1;
        job_o.val_word = val_zz64;
      end
      K_BOOL: begin
        is_hdr   = 1'b1;
        hdr_type = (value_i != '0) ? CT_TRUE : CT_FALSE;
      end
      K_BINARY: begin
        is_hdr         = 1'b1;
        hdr_type       = CT_BINARY;
        job_o.has_val  = 1'b1;
        job_o.val_word = value_i;
      end
      K_LIST: begin
        is_hdr        = 1'b1;
        hdr_type      = CT_LIST;
        job_o.has_mid = 1'b1;
        if (value_i < SHORT_LIST_MAX) begin
          job_o.mid_byte = {value_i[3:0], etype_i};
        end else begin
          job_o.mid_byte = {LIST_LONG_NIB, etype_i};
          job_o.has_val  = 1'b1;
          job_o.val_word = value_i;
        end
      end
      K_STRUCT: begin
        is_hdr    = 1'b1;
        hdr_type  = CT_STRUCT;
        do_push   = 1'b1;
        push_id   = field_id_i;
        job_o.err = stack_full;
      end
      K_BARE_STRUCT: begin
        do_push = 1'b1;
        enq     = 1'b0;
      end
      K_STOP: begin
        job_o.has_mid  = 1'b1;
        job_o.mid_byte = STOP_BYTE;
        if (lvl_q != '0) begin
          lvl_d    = lvl_m1;
          cur_id_d = stack_q[lvl_m1[IDX_W-1:0]];
        end else begin
          cur_id_d = '0;
        end
      end
      K_UVAR: begin
        job_o.has_val  = 1'b1;
        job_o.val_word = value_i;
      end
      K_ZZ32: begin
        job_o.has_val  = 1'b1;
        job_o.val_word = val_zz32;
      end
      K_ZZ64: begin
        job_o.has_val  = 1'b1;
        job_o.val_word = val_zz64;
      end
      K_RAW: begin
        job_o.has_mid  = 1'b1;
        job_o.mid_byte = value_i[7:0];
      end
      default: begin
        enq = 1'b0;
      end
    endcase
    if (is_hdr) begin
      job_o.has_hdr  = 1'b1;
      job_o.hdr_byte = short_hdr ? {delta[3:0], hdr_type} : {4'd0, hdr_type};
      job_o.has_idv  = !short_hdr;
      job_o.idv      = id_zz;
      cur_id_d       = field_id_i;
    end
    // Enter a new level: save the id if the stack has room, restart the delta chain at zero
    if (do_push) begin
      cur_id_d = '0;
      if (!stack_full) begin
        lvl_d = lvl_q + LVL_W'(1);
      end
    end
  end

  assign job_push_o = tok_fire_i && enq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_id_q <= '0;
      lvl_q    <= '0;
    end else if (tok_fire_i) begin
      cur_id_q <= cur_id_d;
      lvl_q    <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_fire_i && do_push && !stack_full) begin
      stack_q[lvl_q[IDX_W-1:0]] <= push_id;
    end
  end

endmodule

[design/cse_fifo.sv]
// ----------------------------------------------------------------------------
// cse_fifo
// Short job queue that decouples the token front from the byte back end.
// ----------------------------------------------------------------------------
module cse_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cse_pkg::job_t push_data_i,
  input  logic          pop_i,
  output cse_pkg::job_t pop_data_o,
  output logic          empty_o,
  output logic          full_o
);
  import cse_pkg::*;

  job_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q;
  logic [FIFO_AW-1:0] rd_ptr_q;
  logic [FIFO_CW-1:0] count_q;
  logic               do_push;
  logic               do_pop;

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == FIFO_CW'(FIFO_DEPTH));
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FIFO_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + FIFO_CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - FIFO_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[design/cse_back.sv]
// ----------------------------------------------------------------------------
// cse_back
// Byte back end: emits a job's segments one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module cse_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cse_pkg::job_t job_i,
  input  logic          job_empty_i,
  output logic          job_pop_o,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,
  output logic          m_tlast,
  output logic          m_tuser
);
  import cse_pkg::*;

  logic             hdr_pend_q, idv_pend_q, mid_pend_q, val_pend_q;
  logic [7:0]       hdr_q, mid_q;
  logic [FID_W-1:0] idv_q;
  logic [VAL_W-1:0] val_q;
  logic             err_q;
  logic             ovalid_q;
  logic [7:0]       obyte_q;
  logic             olast_q;
  logic             oerr_q;

  logic       busy;
  logic       slot_free;
  logic       fire;
  logic [7:0] byte_c;
  logic       seg_done;
  logic       later;

  assign busy      = hdr_pend_q | idv_pend_q | mid_pend_q | val_pend_q;
  assign slot_free = !ovalid_q || m_tready;
  assign fire      = busy && slot_free;
  assign job_pop_o = !busy && !job_empty_i;

  // Pick the first pending segment
  always_comb begin
    byte_c   = hdr_q;
    seg_done = 1'b1;
    later    = idv_pend_q | mid_pend_q | val_pend_q;
    if (!hdr_pend_q) begin
      if (idv_pend_q) begin
        seg_done = (idv_q[FID_W-1:7] == '0);
        byte_c   = {!seg_done, idv_q[6:0]};
        later    = mid_pend_q | val_pend_q;
      end else if (mid_pend_q) begin
        byte_c = mid_q;
        later  = val_pend_q;
      end else begin
        seg_done = (val_q[VAL_W-1:7] == '0);
        byte_c   = {!seg_done, val_q[6:0]};
        later    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pend_q <= 1'b0;
      idv_pend_q <= 1'b0;
      mid_pend_q <= 1'b0;
      val_pend_q <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      if (job_pop_o) begin
        hdr_pend_q <= job_i.has_hdr;
        idv_pend_q <= job_i.has_idv;
        mid_pend_q <= job_i.has_mid;
        val_pend_q <= job_i.has_val;
      end else if (fire) begin
        if (hdr_pend_q) begin
          hdr_pend_q <= 1'b0;
        end else if (idv_pend_q) begin
          idv_pend_q <= !seg_done;
        end else if (mid_pend_q) begin
          mid_pend_q <= 1'b0;
        end else begin
          val_pend_q <= !seg_done;
        end
      end
      if (fire) begin
        ovalid_q <= 1'b1;
      end else if (m_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      hdr_q <= job_i.hdr_byte;
      idv_q <= job_i.idv;
      mid_q <= job_i.mid_byte;
      val_q <= job_i.val_word;
      err_q <= job_i.err;
    end else if (fire) begin
      // Shift out the seven bits just sent
      if (!hdr_pend_q && idv_pend_q) begin
        idv_q <= idv_q >> 7;
      end
      if (!hdr_pend_q && !idv_pend_q && !mid_pend_q) begin
        val_q <= val_q >> 7;
      end
    end
    if (fire) begin
      obyte_q <= byte_c;
      olast_q <= seg_done && !later;
      oerr_q  <= err_q;
    end
  end

  assign m_tvalid = ovalid_q;
  assign m_tdata  = obyte_q;
  assign m_tlast  = olast_q;
  assign m_tuser  = oerr_q;

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stream-level testbench for the compact struct field encoder.
// ----------------------------------------------------------------------------
// Serializer tokens go in on the slave stream; every encoded byte that comes
// out on the master stream is compared with a byte predicted in the bench.
// A directed table opens the run: extreme field ids and values, every token
// kind, the short and long header forms, short and long list sizes, a full
// nesting stack with its overflow flag, and an unused kind. A random part
// follows. It is mostly well-formed struct streams (fields, lists with
// elements, binaries with payload, nested structs closed by stops) and partly
// noise, run through four phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cse_pkg::*;

  // Kind code that the encoder must ignore
  localparam logic [3:0] KIND_RESERVED = 4'd15;

  localparam int RAND_ITEMS = 450;
  localparam int PHASES     = 4;
  localparam int TAIL_WAIT  = 40;  // idle time after the last byte: covers a full job

  // One serializer token; rows of the directed table may carry their
  // expected bytes typed in (first byte in the highest used bits)
  typedef struct {
    logic [3:0]   kind;
    logic [15:0]  fid;
    logic [63:0]  val;
    logic [3:0]   et;
    int           n_typed;
    logic [127:0] typed;
    bit           typed_err;
  } token_t;

  // One encoded byte as it should appear on the master stream
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       err;
  } enc_byte_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata  = '0;   // [15:0] field_id, [79:16] value,
                                // [83:80] etype, [87:84] zero
  logic [3:0]  s_tuser  = '0;   // [3:0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [7:0] out_byte
  logic        m_tlast;
  logic        m_tuser;         // [0] nest_error

  compact_struct_field_encoder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Encoder state as the bench sees it
  logic [15:0] prev_fid;
  logic [15:0] fid_stack [STACK_DEPTH];
  int          stack_lvl;

  // Bytes of the token being predicted, and the store of bytes still owed
  logic [7:0]  tok_bytes [$];
  logic        tok_err;
  enc_byte_t   pending_bytes [$];

  // Idling knobs, in percent per cycle
  int idle_pct  = 0;
  int stall_pct = 0;

  // Bookkeeping for the summary
  int errors      = 0;
  int items_sent  = 0;
  int bytes_seen  = 0;
  int overflows   = 0;
  int deepest     = 0;
  int open_lvls   = 0;

  initial forever #2 clk_i = ~clk_i;

  // Hard stop if the stream ever hangs
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] zz32(logic [31:0] s);
    return {s[30:0], 1'b0} ^ {32{s[31]}};
  endfunction

  function automatic logic [63:0] zz64(logic [63:0] s);
    return {s[62:0], 1'b0} ^ {64{s[63]}};
  endfunction

  // LEB128: seven bits per byte, continuation flag in bit 7
  function automatic void put_varint(logic [63:0] v);
    while (v >= 64'h80) begin
      tok_bytes.push_back({1'b1, v[6:0]});
      v = v >> 7;
    end
    tok_bytes.push_back(v[7:0]);
  endfunction

  // Field header: delta nibble when the step is 1..15, else bare type byte
  // followed by the zigzag id
  function automatic void put_header(logic [15:0] fid, logic [3:0] ct);
    logic [15:0] delta;
    delta = fid - prev_fid;
    if (delta >= 16'd1 && delta <= 16'd15) begin
      tok_bytes.push_back({delta[3:0], ct});
    end else begin
      tok_bytes.push_back({4'h0, ct});
      put_varint({32'h0, zz32({{16{fid[15]}}, fid})});
    end
    prev_fid = fid;
  endfunction

  // Save the current id for the enclosing level; on a full stack save
  // nothing, but still restart the inner level at zero
  function automatic bit push_level();
    bit full;
    full = (stack_lvl >= STACK_DEPTH);
    if (!full) begin
      fid_stack[stack_lvl] = prev_fid;
      stack_lvl++;
      if (stack_lvl > deepest) deepest = stack_lvl;
    end else begin
      overflows++;
    end
    prev_fid = '0;
    return full;
  endfunction

  function automatic void encode_token(token_t t);
    tok_bytes.delete();
    tok_err = 1'b0;
    case (t.kind)
      K_I32: begin
        put_header(t.fid, CT_I32);
        put_varint({32'h0, zz32(t.val[31:0])});
      end
      K_I64: begin
        put_header(t.fid, CT_I64);
        put_varint(zz64(t.val));
      end
      K_BOOL: put_header(t.fid, (t.val != '0) ? CT_TRUE : CT_FALSE);
      K_BINARY: begin
        put_header(t.fid, CT_BINARY);
        put_varint(t.val);
      end
      K_LIST: begin
        put_header(t.fid, CT_LIST);
        if (t.val < SHORT_LIST_MAX) begin
          tok_bytes.push_back({t.val[3:0], t.et});
        end else begin
          tok_bytes.push_back({LIST_LONG_NIB, t.et});
          put_varint(t.val);
        end
      end
      K_STRUCT: begin
        put_header(t.fid, CT_STRUCT);
        tok_err = push_level();
      end
      K_BARE_STRUCT: void'(push_level());
      K_STOP: begin
        tok_bytes.push_back(STOP_BYTE);
        if (stack_lvl > 0) begin
          stack_lvl--;
          prev_fid = fid_stack[stack_lvl];
        end else begin
          prev_fid = '0;
        end
      end
      K_UVAR: put_varint(t.val);
      K_ZZ32: put_varint({32'h0, zz32(t.val[31:0])});
      K_ZZ64: put_varint(zz64(t.val));
      K_RAW:  tok_bytes.push_back(t.val[7:0]);
      default: ;  // unused kinds: no bytes, no state change
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Master side: stall at random, check every transaction against the
  // oldest byte still owed
  // ---------------------------------------------------------------------------
  function automatic void check_byte();
    enc_byte_t e;
    if (pending_bytes.size() == 0) begin
      $error("unexpected output byte %02h", m_tdata);
      errors++;
      return;
    end
    e = pending_bytes.pop_front();
    bytes_seen++;
    if (m_tdata !== e.data) begin
      $error("out_byte: expected %02h, got %02h", e.data, m_tdata);
      errors++;
    end
    if (m_tlast !== e.last) begin
      $error("last_byte: expected %0b, got %0b", e.last, m_tlast);
      errors++;
    end
    if (m_tuser !== e.err) begin
      $error("nest_error: expected %0b, got %0b", e.err, m_tuser);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    // sample before the new ready takes effect
    if (rst_ni && m_tvalid && m_tready) check_byte();
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Slave side
  // ---------------------------------------------------------------------------
  function automatic int sender_gap();
    int n = 0;
    while (n < 24 && $urandom_range(99) < idle_pct) n++;
    return n;
  endfunction

  // Present one token, hold it until the transaction completes, then
  // predict its bytes (or take the typed-in ones) and queue them
  task automatic drive_token(token_t t);
    int gap;
    int k;
    gap = sender_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= t.kind;
    s_tdata  <= {4'h0, t.et, t.val, t.fid};
    do @(posedge clk_i); while (s_tready !== 1'b1);
    encode_token(t);
    if (t.n_typed > 0) begin
      tok_bytes.delete();
      for (k = 0; k < t.n_typed; k++)
        tok_bytes.push_back(t.typed[8*(t.n_typed-1-k) +: 8]);
      tok_err = t.typed_err;
    end
    for (k = 0; k < tok_bytes.size(); k++)
      pending_bytes.push_back('{tok_bytes[k], k == tok_bytes.size() - 1, tok_err});
    if (t.kind <= K_RAW) items_sent++;
  endtask

  // Drop valid and hold off until every owed byte has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_bytes.size() != 0);
  endtask

  function automatic token_t mk_tok(logic [3:0] kind, logic [15:0] fid, logic [63:0] val,
                                    logic [3:0] et, int n = 0, logic [127:0] typed = '0,
                                    bit terr = 1'b0);
    token_t t;
    t.kind      = kind;
    t.fid       = fid;
    t.val       = val;
    t.et        = et;
    t.n_typed   = n;
    t.typed     = typed;
    t.typed_err = terr;
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------
  // Mostly a short step from the last id, so the delta form gets used;
  // sometimes a zero, backward or arbitrary step for the long form
  function automatic logic [15:0] next_fid();
    case ($urandom_range(9))
      0:       return 16'($urandom);
      1:       return prev_fid;
      2:       return prev_fid - 16'($urandom_range(1, 40));
      default: return prev_fid + 16'($urandom_range(1, 15));
    endcase
  endfunction

  function automatic logic [63:0] rand_val();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(5))
      0: return 64'($urandom_range(300));
      1: return 64'h0 - 64'($urandom_range(300));
      2: return {$urandom, $urandom};
      3: return 64'h1 << $urandom_range(63);
      4: begin
        case ($urandom_range(3))
          0:       return 64'h7FFF_FFFF_FFFF_FFFF;
          1:       return 64'h8000_0000_0000_0000;
          2:       return '1;
          default: return '0;
        endcase
      end
      default: return {{32{r[31]}}, r};
    endcase
  endfunction

  function automatic logic [3:0] elem_kind();
    case ($urandom_range(2))
      0:       return K_ZZ32;
      1:       return K_ZZ64;
      default: return K_UVAR;
    endcase
  endfunction

  // Feed one phase: well-formed struct streams with random content, a
  // quarter of noise tokens of any kind and operand
  task automatic run_phase(int target);
    int start;
    int n;
    int k;
    logic [63:0] v;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(99) < 25) begin
        drive_token(mk_tok(4'($urandom_range(15)), 16'($urandom), rand_val(),
                           4'($urandom_range(15))));
      end else if (open_lvls > 0 &&
                   $urandom_range(99) < ((open_lvls > STACK_DEPTH) ? 60 : 12)) begin
        drive_token(mk_tok(K_STOP, next_fid(), rand_val(), 4'($urandom_range(15))));
        open_lvls--;
      end else begin
        case ($urandom_range(7))
          0: drive_token(mk_tok(K_I32, next_fid(), rand_val(), 4'h0));
          1: drive_token(mk_tok(K_I64, next_fid(), rand_val(), 4'h0));
          2: drive_token(mk_tok(K_BOOL, next_fid(),
                                ($urandom_range(2) == 0) ? rand_val() : 64'($urandom_range(1)),
                                4'h0));
          3: begin
            // binary header, then its payload as raw bytes
            n = $urandom_range(4);
            drive_token(mk_tok(K_BINARY, next_fid(), 64'(n), 4'h0));
            for (k = 0; k < n; k++)
              drive_token(mk_tok(K_RAW, 16'($urandom), rand_val(), 4'h0));
          end
          4: begin
            // list header around the short/long size boundary, a few elements
            v = ($urandom_range(9) == 0) ? rand_val() : 64'($urandom_range(20));
            drive_token(mk_tok(K_LIST, next_fid(), v, 4'($urandom_range(15))));
            n = (v < 64'd3) ? int'(v) : 3;
            for (k = 0; k < n; k++)
              drive_token(mk_tok(elem_kind(), 16'($urandom), rand_val(), 4'h0));
          end
          5: begin
            drive_token(mk_tok(K_STRUCT, next_fid(), rand_val(), 4'h0));
            open_lvls++;
          end
          6: begin
            drive_token(mk_tok(K_BARE_STRUCT, 16'($urandom), rand_val(), 4'h0));
            open_lvls++;
          end
          default: drive_token(mk_tok(elem_kind(), 16'($urandom), rand_val(),
                                      4'($urandom_range(15))));
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  token_t dir_tab [$];
  int     n_directed;

  initial begin
    int i;
    prev_fid  = '0;
    stack_lvl = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Typed-in bytes where they read straight off the format.
    dir_tab.push_back(mk_tok(K_STOP, 16'h0000, '0, 4'h0, 1, 'h00));       // stop at top
    dir_tab.push_back(mk_tok(K_BOOL, 16'h0001, 64'd1, 4'h0, 1, 'h11));
    dir_tab.push_back(mk_tok(K_BOOL, 16'h0002, 64'd0, 4'h0, 1, 'h12));
    dir_tab.push_back(mk_tok(K_I32, 16'h0003, 64'd0, 4'h0, 2, 'h1500));
    dir_tab.push_back(mk_tok(K_I32, 16'h0004, 64'h7FFF_FFFF, 4'h0, 6, 'h15_FEFFFFFF0F));
    dir_tab.push_back(mk_tok(K_I64, 16'h0005, 64'h8000_0000_0000_0000, 4'h0, 11,
                             'h16_FFFFFFFFFFFFFFFFFF_01));
    // zero delta: long header form
    dir_tab.push_back(mk_tok(K_I64, 16'h0005, 64'h7FFF_FFFF_FFFF_FFFF, 4'h0, 12,
                             'h06_0A_FE_FFFFFFFFFFFFFFFF_01));
    // large positive delta to the most negative id
    dir_tab.push_back(mk_tok(K_I32, 16'h8000, '1, 4'h0, 5, 'h05_FFFF03_01));
    // negative delta to the most positive id
    dir_tab.push_back(mk_tok(K_BINARY, 16'h7FFF, 64'd5, 4'h0, 5, 'h08_FEFF03_05));
    dir_tab.push_back(mk_tok(K_RAW, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFAB, 4'hF, 1, 'hAB));
    // list sizes either side of the short form limit, and the largest
    dir_tab.push_back(mk_tok(K_LIST, 16'h8001, 64'd14, 4'hF, 2, 'h29EF));
    dir_tab.push_back(mk_tok(K_LIST, 16'h8002, 64'd15, 4'h3, 3, 'h19F30F));
    dir_tab.push_back(mk_tok(K_LIST, 16'h8003, '1, 4'h0));
    dir_tab.push_back(mk_tok(K_UVAR, 16'h0000, 64'd128, 4'h0, 2, 'h8001));
    dir_tab.push_back(mk_tok(K_ZZ32, 16'h0000, 64'hFFFF_FFFF_8000_0000, 4'h0));
    dir_tab.push_back(mk_tok(K_ZZ64, 16'h0000, 64'h8000_0000_0000_0000, 4'h0));
    // fill the nesting stack with a mix of struct fields and bare starts
    dir_tab.push_back(mk_tok(K_STRUCT, 16'h0010, '0, 4'h0));
    dir_tab.push_back(mk_tok(K_BARE_STRUCT, 16'h0000, '0, 4'h0));
    dir_tab.push_back(mk_tok(K_STRUCT, 16'h0007, '0, 4'h0));
    dir_tab.push_back(mk_tok(K_BARE_STRUCT, 16'h0000, '0, 4'h0));
    dir_tab.push_back(mk_tok(K_STRUCT, 16'h000F, '0, 4'h0));
    dir_tab.push_back(mk_tok(K_BARE_STRUCT, 16'h0000, '0, 4'h0));
    dir_tab.push_back(mk_tok(K_BARE_STRUCT, 16'h0000, '0, 4'h0));
    dir_tab.push_back(mk_tok(K_STRUCT, 16'h0010, '0, 4'h0));
    // stack full: struct field flags the overflow, bare start stays silent
    dir_tab.push_back(mk_tok(K_STRUCT, 16'h0001, '0, 4'h0, 1, 'h1C, 1'b1));
    dir_tab.push_back(mk_tok(K_BARE_STRUCT, 16'h0000, '0, 4'h0));
    dir_tab.push_back(mk_tok(K_STOP, 16'h0000, '0, 4'h0, 1, 'h00));
    dir_tab.push_back(mk_tok(KIND_RESERVED, 16'hFFFF, '1, 4'hF));  // ignored

    for (i = 0; i < dir_tab.size(); i++) drive_token(dir_tab[i]);
    n_directed = items_sent;
    drain();

    // Random phases: free flow, sender idle, receiver stall, both
    for (i = 0; i < PHASES; i++) begin
      case (i)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 55; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      run_phase(RAND_ITEMS / PHASES);
      drain();
    end

    stall_pct = 0;
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("Sent %0d tokens (%0d from the directed table), checked %0d encoded bytes",
             items_sent, n_directed, bytes_seen);
    $display("Nesting reached depth %0d, with %0d pushes on a full stack",
             deepest, overflows);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
design/cse_pkg.sv
design/cse_front.sv
design/cse_fifo.sv
design/cse_back.sv
design/compact_struct_field_encoder.sv
dv/tb_top.sv
